@@ hdl/mmba_pkg.sv @@
// Shared constants and control/status types of the multi-mode bounded accumulator.
package mmba_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 2;
  localparam int DIR_W      = 2;
  localparam int BOUND_W    = 16;
  localparam int OUT_W      = 16;
  // remainder register: range is at most 2^16, one extra bit for the shifted trial
  localparam int REM_W      = 18;

  localparam logic [MODE_W-1:0] MODE_WRAP     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PENDULUM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_FREEZE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP     = 2'b01;

  localparam logic signed [DIR_W-1:0] SENSE_UP   = 2'sb01;
  localparam logic signed [DIR_W-1:0] SENSE_DOWN = 2'sb11;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic fold;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/multi_mode_bounded_accumulator_unit.sv @@
// Top level of the multi-mode bounded accumulator: controller, datapath and checks.
// Each request carries a tick direction and produces one result: the counter
// after the tick and the pendulum travel sense. A request in hold, pendulum or
// return-to-zero mode, a freeze tick, or a wrap tick with an empty range goes
// from load straight to commit. A wrap tick with a nonempty range runs a prep
// step, a bit-serial remainder, one bit per cycle over max(COUNT_WIDTH,16)+3
// bits, and a fold step before the commit. One request is in flight at a time;
// a finished result waits in the output register and only blocks the next
// commit, not the next acceptance.
module multi_mode_bounded_accumulator_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mmba_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mmba_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mmba_pkg::DIR_W-1:0]      in_direction_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [mmba_pkg::OUT_W-1:0]      out_count_value_o,
  output logic signed [mmba_pkg::DIR_W-1:0]      out_travel_sense_o
);

  mmba_pkg::cmd_t    cmd;
  mmba_pkg::status_t status;

  mmba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mmba_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_direction_i     (in_direction_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_count_value_o  (out_count_value_o),
    .out_travel_sense_o (out_travel_sense_o)
  );

  // an accepted request keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but block not busy");

  // a new result only appears from a request in flight
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

  // reported travel sense is always plus or minus one
  a_sense_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_travel_sense_o == mmba_pkg::SENSE_UP) ||
                     (out_travel_sense_o == mmba_pkg::SENSE_DOWN)))
    else $error("illegal travel sense");

endmodule

@@ hdl/mmba_ctrl.sv @@
// Sequencing state machine of the multi-mode bounded accumulator.
module mmba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mmba_pkg::status_t   status_i,
  output mmba_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.need_div ? ST_PREP : ST_FIN;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // wait for room in the output register
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ hdl/mmba_dp.sv @@
// Datapath: config registers, counter state, bit-serial modulo and result register.
module mmba_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mmba_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mmba_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic signed [mmba_pkg::DIR_W-1:0]      in_direction_i,
  input  mmba_pkg::cmd_t                         cmd_i,
  output mmba_pkg::status_t                      status_o,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [mmba_pkg::OUT_W-1:0]      out_count_value_o,
  output logic signed [mmba_pkg::DIR_W-1:0]      out_travel_sense_o
);

  localparam int W       = COUNT_WIDTH;
  localparam int BOUND_W = mmba_pkg::BOUND_W;
  localparam int REM_W   = mmba_pkg::REM_W;
  localparam int OUT_W   = mmba_pkg::OUT_W;
  localparam int SUM_W   = ((W > BOUND_W) ? W : BOUND_W) + 2;
  localparam int DIFF_W  = SUM_W + 1;
  localparam int CNT_W   = $clog2(DIFF_W + 1);

  // configuration
  logic [mmba_pkg::MODE_W-1:0] mode_q;
  logic signed [BOUND_W-1:0]   lower_q, upper_q, step_q;

  // block state
  logic signed [W-1:0] count_q;
  logic                sense_up_q;

  // per-request working registers
  logic signed [SUM_W-1:0] sum_q;
  logic                    frozen_q, up_q;
  logic [DIFF_W-1:0]       mag_q;
  logic                    neg_q;
  logic [REM_W-1:0]        rem_q;
  logic [CNT_W-1:0]        cnt_q;

  // result register
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_count_q;
  logic signed [1:0]       out_sense_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mmba_pkg::MODE_WRAP;
      lower_q <= 16'sd0;
      upper_q <= 16'sd15;
      step_q  <= 16'sd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mmba_pkg::CFG_MODE:  mode_q  <= cfg_wdata_i[mmba_pkg::MODE_W-1:0];
        mmba_pkg::CFG_LOWER: lower_q <= $signed(cfg_wdata_i);
        mmba_pkg::CFG_UPPER: upper_q <= $signed(cfg_wdata_i);
        mmba_pkg::CFG_STEP:  step_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // range = upper - lower + 1, positive only for a nonempty range
  logic signed [REM_W-1:0] range_s;
  logic                    range_pos;
  logic [REM_W-2:0]        range_u;
  assign range_s   = REM_W'(upper_q) - REM_W'(lower_q) + REM_W'(1);
  assign range_pos = !range_s[REM_W-1] && (range_s != '0);
  assign range_u   = range_s[REM_W-2:0];

  logic up_c, frozen_c, go_up;
  logic signed [SUM_W-1:0] step_e, sum_d;
  assign up_c     = (in_direction_i == mmba_pkg::DIR_UP);
  assign frozen_c = (in_direction_i == mmba_pkg::DIR_FREEZE);
  assign go_up    = (mode_q == mmba_pkg::MODE_PENDULUM) ? sense_up_q : up_c;
  assign step_e   = SUM_W'(step_q);
  assign sum_d    = SUM_W'(count_q) + (go_up ? step_e : -step_e);

  // signed offset from the lower bound, split into sign and magnitude
  logic signed [DIFF_W-1:0] diff_c;
  assign diff_c = DIFF_W'(sum_q) - DIFF_W'(lower_q);

  // one restoring remainder step
  logic [REM_W-1:0] trial_c, rem_step_c;
  assign trial_c    = {rem_q[REM_W-2:0], mag_q[DIFF_W-1]};
  assign rem_step_c = (trial_c >= {1'b0, range_u}) ? (trial_c - {1'b0, range_u}) : trial_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q    <= sum_d;
      frozen_q <= frozen_c;
      up_q     <= up_c;
    end
    if (cmd_i.prep) begin
      neg_q <= diff_c[DIFF_W-1];
      mag_q <= diff_c[DIFF_W-1] ? unsigned'(-diff_c) : unsigned'(diff_c);
      rem_q <= '0;
      cnt_q <= CNT_W'(DIFF_W);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_step_c;
      mag_q <= mag_q << 1;
      cnt_q <= cnt_q - CNT_W'(1);
    end else if (cmd_i.fold) begin
      // negative offset: true positive modulo
      if (neg_q && (rem_q != '0)) begin
        rem_q <= {1'b0, range_u} - rem_q;
      end
    end
  end

  // bound the stepped value per mode
  logic signed [SUM_W-1:0] hi_e, lo_e, wrap_c, res_c;
  logic                    flip_c;
  assign hi_e   = SUM_W'(upper_q);
  assign lo_e   = SUM_W'(lower_q);
  assign wrap_c = lo_e + $signed(SUM_W'(rem_q));

  always_comb begin
    res_c  = sum_q;
    flip_c = 1'b0;
    case (mode_q)
      mmba_pkg::MODE_WRAP: begin
        if (range_pos) begin
          res_c = wrap_c;
        end
      end
      mmba_pkg::MODE_PENDULUM: begin
        if (sum_q >= hi_e) begin
          res_c  = hi_e;
          flip_c = 1'b1;
        end else if (sum_q <= lo_e) begin
          res_c  = lo_e;
          flip_c = 1'b1;
        end
      end
      mmba_pkg::MODE_HOLD: begin
        if (up_q && (sum_q >= hi_e)) begin
          res_c = hi_e;
        end else if (!up_q && (sum_q <= lo_e)) begin
          res_c = lo_e;
        end
      end
      default: begin
        if ((sum_q > hi_e) || (sum_q < lo_e)) begin
          res_c = '0;
        end
      end
    endcase
  end

  // saturate to the counter width
  logic [SUM_W-W:0]    top_c;
  logic                fits_c;
  logic signed [W-1:0] sat_c, next_count_c;
  logic                next_sense_c;
  assign top_c  = res_c[SUM_W-1:W-1];
  assign fits_c = (&top_c) || !(|top_c);
  assign sat_c  = fits_c ? res_c[W-1:0]
                : (res_c[SUM_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign next_count_c = frozen_q ? count_q : sat_c;
  assign next_sense_c = (frozen_q || !flip_c) ? sense_up_q : !sense_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sense_up_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= next_count_c;
        sense_up_q  <= next_sense_c;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_count_q <= OUT_W'(next_count_c);
      out_sense_q <= next_sense_c ? mmba_pkg::SENSE_UP : mmba_pkg::SENSE_DOWN;
    end
  end

  assign status_o.need_div = !frozen_c && (mode_q == mmba_pkg::MODE_WRAP) && range_pos;
  assign status_o.div_last = (cnt_q == CNT_W'(1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign out_count_value_o  = out_count_q;
  assign out_travel_sense_o = out_sense_q;

endmodule

@@ tb/multi_mode_bounded_accumulator_unit_tb.sv @@
// Testbench for the multi-mode bounded accumulator: tick predictor, drivers and checks.
`timescale 1ns / 100ps

module multi_mode_bounded_accumulator_unit_tb;

  localparam int COUNT_W      = 16;
  localparam int SETTLE_CYC   = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [mmba_pkg::DIR_W-1:0] DIR_DOWN     = 2'b11;
  localparam logic [mmba_pkg::DIR_W-1:0] DIR_DOWN_ALT = 2'b10;  // -2 still counts as down

  // Tracks counter/sense state and the queue of counts still owed by the block.
  class count_tracker;
    logic [mmba_pkg::MODE_W-1:0] mode_q;
    longint                      lower_q, upper_q, step_q, count_q;
    bit                          sense_up_q;
    logic [mmba_pkg::OUT_W-1:0]  exp_counts[$];
    logic [mmba_pkg::DIR_W-1:0]  exp_senses[$];
    int                          errors;

    function new();
      mode_q     = mmba_pkg::MODE_WRAP;
      lower_q    = 0;
      upper_q    = 15;
      step_q     = 1;
      count_q    = 0;
      sense_up_q = 1'b1;
      errors     = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(logic [mmba_pkg::CFG_IDX_W-1:0] idx,
                            logic [mmba_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mmba_pkg::CFG_MODE:  mode_q  = data[mmba_pkg::MODE_W-1:0];
        mmba_pkg::CFG_LOWER: lower_q = longint'($signed(data));
        mmba_pkg::CFG_UPPER: upper_q = longint'($signed(data));
        mmba_pkg::CFG_STEP:  step_q  = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function int pending();
      return exp_counts.size();
    endfunction

    function void predict_tick(logic [mmba_pkg::DIR_W-1:0] dir);
      longint c, span, r, sat_hi, sat_lo;
      bit up;
      sat_hi = (longint'(1) << (COUNT_W - 1)) - 1;
      sat_lo = -sat_hi - 1;
      c  = count_q;
      up = (dir == mmba_pkg::DIR_UP);
      if (dir != mmba_pkg::DIR_FREEZE) begin
        if (mode_q == mmba_pkg::MODE_PENDULUM) begin
          // direction only gates the tick; travel sense picks the sign
          c += sense_up_q ? step_q : -step_q;
          if (c >= upper_q) begin
            c = upper_q;
            sense_up_q = !sense_up_q;
          end else if (c <= lower_q) begin
            c = lower_q;
            sense_up_q = !sense_up_q;
          end
        end else begin
          c += up ? step_q : -step_q;
          case (mode_q)
            mmba_pkg::MODE_WRAP: begin
              span = upper_q - lower_q + 1;
              if (span > 0) begin
                r = (c - lower_q) % span;
                if (r < 0) r += span;
                c = lower_q + r;
              end
            end
            mmba_pkg::MODE_HOLD: begin
              if (up) begin
                if (c >= upper_q) c = upper_q;
              end else if (c <= lower_q) begin
                c = lower_q;
              end
            end
            default: if (c > upper_q || c < lower_q) c = 0;
          endcase
        end
        if (c > sat_hi) c = sat_hi;
        else if (c < sat_lo) c = sat_lo;
        count_q = c;
      end
      exp_counts.push_back(count_q[mmba_pkg::OUT_W-1:0]);
      exp_senses.push_back(sense_up_q ? mmba_pkg::SENSE_UP : mmba_pkg::SENSE_DOWN);
    endfunction

    task check_count(logic [mmba_pkg::OUT_W-1:0] cnt, logic [mmba_pkg::DIR_W-1:0] sense);
      logic [mmba_pkg::OUT_W-1:0] want_cnt;
      logic [mmba_pkg::DIR_W-1:0] want_sense;
      if (exp_counts.size() == 0) begin
        report($sformatf("result %0d with no request waiting", $signed(cnt)));
      end else begin
        want_cnt   = exp_counts.pop_front();
        want_sense = exp_senses.pop_front();
        if (cnt !== want_cnt)
          report($sformatf("count_value %0d, want %0d", $signed(cnt), $signed(want_cnt)));
        if (sense !== want_sense)
          report($sformatf("travel_sense %0d, want %0d", $signed(sense),
                           $signed(want_sense)));
      end
    endtask
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [mmba_pkg::CFG_IDX_W-1:0]       cfg_index_i = mmba_pkg::CFG_MODE;
  logic [mmba_pkg::CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic signed [mmba_pkg::DIR_W-1:0]    in_direction_i = mmba_pkg::DIR_FREEZE;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [mmba_pkg::OUT_W-1:0]    out_count_value_o;
  logic signed [mmba_pkg::DIR_W-1:0]    out_travel_sense_o;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles;

  count_tracker tracker = new();

  multi_mode_bounded_accumulator_unit #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_direction_i     (in_direction_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_count_value_o  (out_count_value_o),
    .out_travel_sense_o (out_travel_sense_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: values seen at the edge are the ones from before it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_count(out_count_value_o, out_travel_sense_o);
    out_stall_i <= (int'($urandom_range(99)) < stall_pct);
  end

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_tick(logic [mmba_pkg::DIR_W-1:0] dir);
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_direction_i <= dir;
    do @(posedge clk_i); while (in_stall_o);
    tracker.predict_tick(dir);
  endtask

  // hold off requests until every owed result is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apply_config(int m, int lo, int hi, int st);
    logic [mmba_pkg::CFG_DATA_W-1:0] vals[4];
    logic [mmba_pkg::CFG_IDX_W-1:0]  idx;
    vals[mmba_pkg::CFG_MODE]  = mmba_pkg::CFG_DATA_W'(m);
    vals[mmba_pkg::CFG_LOWER] = mmba_pkg::CFG_DATA_W'(lo);
    vals[mmba_pkg::CFG_UPPER] = mmba_pkg::CFG_DATA_W'(hi);
    vals[mmba_pkg::CFG_STEP]  = mmba_pkg::CFG_DATA_W'(st);
    settle();
    for (int i = 0; i < 4; i++) begin
      idx = mmba_pkg::CFG_IDX_W'(i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      tracker.write_reg(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_random_config();
    int m, lo, hi, st;
    m = int'($urandom_range(3));
    case ($urandom_range(9))
      0: begin
        lo = -32768;
        hi = 32767;
      end
      1: begin  // empty range
        lo = int'($urandom_range(60)) - 20;
        hi = lo - 1 - int'($urandom_range(30));
      end
      2: begin
        hi = 32767 - int'($urandom_range(3));
        lo = hi - int'($urandom_range(40));
      end
      3: begin
        lo = -32768 + int'($urandom_range(3));
        hi = lo + int'($urandom_range(40));
      end
      4: begin
        lo = int'($urandom_range(65535)) - 32768;
        hi = int'($urandom_range(65535)) - 32768;
      end
      default: begin
        lo = int'($urandom_range(200)) - 100;
        hi = lo + int'($urandom_range(25));
      end
    endcase
    case ($urandom_range(7))
      0: st = int'($urandom_range(65535)) - 32768;
      1: st = $urandom_range(1) ? 32767 : -32768;
      2: st = 0;
      default: st = int'($urandom_range(10)) - 5;
    endcase
    apply_config(m, lo, hi, st);
  endtask

  task automatic random_ticks(int n);
    int up_pct, roll;
    up_pct = int'($urandom_range(20, 80));
    for (int i = 0; i < n; i++) begin
      roll = int'($urandom_range(99));
      if (roll < 12) send_tick(mmba_pkg::DIR_FREEZE);
      else if (roll < 20) send_tick(DIR_DOWN_ALT);
      else if (int'($urandom_range(99)) < up_pct) send_tick(mmba_pkg::DIR_UP);
      else send_tick(DIR_DOWN);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: wrap over 0..15, step 1, including the fold below zero
    send_tick(mmba_pkg::DIR_UP);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(mmba_pkg::DIR_FREEZE);
    send_tick(DIR_DOWN);
    send_tick(DIR_DOWN);
    send_tick(DIR_DOWN_ALT);

    // pendulum across the full range with the largest step
    apply_config(mmba_pkg::MODE_PENDULUM, -32768, 32767, 32767);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(mmba_pkg::DIR_FREEZE);
    send_tick(DIR_DOWN);
    send_tick(DIR_DOWN_ALT);
    send_tick(mmba_pkg::DIR_UP);

    // hold with a negative step escapes the range and saturates
    apply_config(mmba_pkg::MODE_HOLD, -100, 100, -32768);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(DIR_DOWN);
    send_tick(DIR_DOWN);

    // return to zero: empty range, then a narrow one
    apply_config(mmba_pkg::MODE_ZERO, 5, 4, 1);
    send_tick(mmba_pkg::DIR_UP);
    apply_config(mmba_pkg::MODE_ZERO, -3, 3, 2);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(DIR_DOWN);

    // wrap with empty range stays unfolded and saturates
    apply_config(mmba_pkg::MODE_WRAP, 10, -10, 32767);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(DIR_DOWN_ALT);

    // wrap over the full 16-bit range
    apply_config(mmba_pkg::MODE_WRAP, -32768, 32767, 32767);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(mmba_pkg::DIR_UP);
    send_tick(DIR_DOWN);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int seg = 0; seg < 10; seg++) begin
        apply_random_config();
        random_ticks(int'($urandom_range(30, 55)));
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
